[rtl/core/frlv_pkg.sv]
package frlv_pkg;

  localparam int unsigned LenWidthDef   = 8;
  localparam int unsigned BlockWidthDef = 16;
  localparam int unsigned AddrWidth     = 4;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_BLOCK_LIMIT = 2'd0;
  localparam logic [1:0] REG_USER_LIMIT  = 2'd1;
  localparam logic [1:0] REG_PATH_LIMIT  = 2'd2;

  localparam logic [15:0] BlockLimitRst = 16'd124;
  localparam logic [7:0]  UserLimitRst  = 8'd10;
  localparam logic [7:0]  PathLimitRst  = 8'd128;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_LOW_D = 8'h64;

  // common head of every keyword
  localparam logic [23:0] KwPrefix = "FS_";

  localparam logic [3:0] KeyPosMax = 4'd15;

  typedef enum logic [5:0] {
    PH_KEY   = 6'b000001,
    PH_USER  = 6'b000010,
    PH_PATH  = 6'b000100,
    PH_DIGIT = 6'b001000,
    PH_TYPE  = 6'b010000,
    PH_BAD   = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_CREATE = 2'd2,
    KIND_DELETE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    TAG_KEYWORD = 3'd0,
    TAG_SPACE   = 3'd1,
    TAG_USER    = 3'd2,
    TAG_PATH    = 3'd3,
    TAG_DIGIT   = 3'd4,
    TAG_TYPE    = 3'd5,
    TAG_ERROR   = 3'd6
  } tag_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_MALFORMED  = 3'd1,
    ERR_TYPE_TOKEN = 3'd2,
    ERR_LEAD_ZERO  = 3'd3,
    ERR_BLOCK      = 3'd4,
    ERR_USER_LEN   = 3'd5,
    ERR_PATH_LEN   = 3'd6,
    ERR_PATH_FORM  = 3'd7
  } err_e;

  typedef struct packed {
    logic [15:0] block_limit;
    logic [7:0]  user_len_limit;
    logic [7:0]  path_len_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  char_out;
    tag_e        field_tag;
    logic        done_res;
    logic        accepted;
    kind_e       request_kind;
    logic [15:0] block_index;
    logic        node_kind;
    err_e        error_code;
  } res_t;

  function automatic logic [3:0] kw_len(input logic [1:0] k);
    logic [3:0] len;
    case (k)
      KIND_READ:   len = 4'd12;
      KIND_WRITE:  len = 4'd13;
      KIND_CREATE: len = 4'd9;
      KIND_DELETE: len = 4'd9;
      default:     len = 4'd0;
    endcase
    return len;
  endfunction

  // Keyword byte at pos; strings are right-justified in the vector
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] pos);
    logic [103:0] text;
    logic [3:0]   len;
    logic [6:0]   sh;
    len = kw_len(k);
    case (k)
      KIND_READ:   text = 104'({KwPrefix, "READBLOCK"});
      KIND_WRITE:  text = 104'({KwPrefix, "WRITEBLOCK"});
      KIND_CREATE: text = 104'({KwPrefix, "CREATE"});
      KIND_DELETE: text = 104'({KwPrefix, "DELETE"});
      default:     text = '0;
    endcase
    sh = {len - 4'd1 - pos, 3'b000};
    if (pos < len) return text[sh +: 8];
    return 8'h00;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic kind_e kind_of(input logic [3:0] m);
    kind_e kd;
    if (m[0])      kd = KIND_READ;
    else if (m[1]) kd = KIND_WRITE;
    else if (m[2]) kd = KIND_CREATE;
    else           kd = KIND_DELETE;
    return kd;
  endfunction

endpackage

[rtl/core/frlv_stream_if.sv]
interface frlv_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       is_last;

  modport source (output valid, output char_in, output is_last, input ready);
  modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

interface frlv_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  char_out;
  logic [2:0]  field_tag;
  logic        done_res;
  logic        accepted;
  logic [1:0]  request_kind;
  logic [15:0] block_index;
  logic        node_kind;
  logic [2:0]  error_code;

  modport source (output valid, output char_out, output field_tag, output done_res,
                  output accepted, output request_kind, output block_index,
                  output node_kind, output error_code, input ready);
  modport sink   (input valid, input char_out, input field_tag, input done_res,
                  input accepted, input request_kind, input block_index,
                  input node_kind, input error_code, output ready);
endinterface

[rtl/core/fs_request_line_validator_unit.sv]
// File-server request line validator.
// req_i (sink) takes one message byte per beat with is_last marking the final
// byte; res_o (source) returns one result beat per byte: the echoed byte, a
// field tag and, on the last byte, the verdict (accepted, request kind, block,
// node kind, error code). Beats move on valid && ready.
// Latency: the result of a byte is presented the cycle after it is taken,
// straight from the result register. Throughput: one byte per cycle while
// the receiver keeps taking results; the parse state is updated in one pass
// per byte, so there is no gap between messages either.
// If the receiver stalls, the result register holds its beat and req_i.ready
// drops until that beat is taken; no byte is lost or repeated.
// The APB port sets block_limit (0x0), user_len_limit (0x4) and path_len_limit
// (0x8); write only while no message is in flight. pready is tied high.
// Reset (rst_ni low, asynchronous) puts the parser at the start of a message,
// empties the result register and loads the limits with 124, 10 and 128.
module fs_request_line_validator_unit #(
  parameter int unsigned LEN_WIDTH   = frlv_pkg::LenWidthDef,
  parameter int unsigned BLOCK_WIDTH = frlv_pkg::BlockWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  frlv_req_if.sink                       req_i,
  frlv_res_if.source                     res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [frlv_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  frlv_pkg::cfg_t cfg_q;
  frlv_pkg::res_t res_d, res_q;
  logic           out_valid_q;
  logic           step;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_limit    <= frlv_pkg::BlockLimitRst;
      cfg_q.user_len_limit <= frlv_pkg::UserLimitRst;
      cfg_q.path_len_limit <= frlv_pkg::PathLimitRst;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        frlv_pkg::REG_BLOCK_LIMIT: cfg_q.block_limit    <= pwdata[15:0];
        frlv_pkg::REG_USER_LIMIT:  cfg_q.user_len_limit <= pwdata[7:0];
        frlv_pkg::REG_PATH_LIMIT:  cfg_q.path_len_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      frlv_pkg::REG_BLOCK_LIMIT: prdata = 32'(cfg_q.block_limit);
      frlv_pkg::REG_USER_LIMIT:  prdata = 32'(cfg_q.user_len_limit);
      frlv_pkg::REG_PATH_LIMIT:  prdata = 32'(cfg_q.path_len_limit);
      default:                   prdata = '0;
    endcase
  end

  assign req_i.ready = !out_valid_q || res_o.ready;
  assign step        = req_i.valid && req_i.ready;

  frlv_parser #(
    .LEN_WIDTH   (LEN_WIDTH),
    .BLOCK_WIDTH (BLOCK_WIDTH)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .char_i (req_i.char_in),
    .last_i (req_i.is_last),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) res_q <= res_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.char_out     = res_q.char_out;
  assign res_o.field_tag    = res_q.field_tag;
  assign res_o.done_res     = res_q.done_res;
  assign res_o.accepted     = res_q.accepted;
  assign res_o.request_kind = res_q.request_kind;
  assign res_o.block_index  = res_q.block_index;
  assign res_o.node_kind    = res_q.node_kind;
  assign res_o.error_code   = res_q.error_code;

endmodule

[rtl/core/frlv_parser.sv]
module frlv_parser #(
  parameter int unsigned LEN_WIDTH   = frlv_pkg::LenWidthDef,
  parameter int unsigned BLOCK_WIDTH = frlv_pkg::BlockWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      char_i,
  input  logic            last_i,
  input  frlv_pkg::cfg_t  cfg_i,
  output frlv_pkg::res_t  res_o
);

  localparam int unsigned CntW   = LEN_WIDTH + 1;
  localparam int unsigned CmpW   = (CntW > 8) ? CntW : 8;
  localparam int unsigned ProdW  = BLOCK_WIDTH + 4;
  localparam int unsigned WideW  = (BLOCK_WIDTH > 16) ? BLOCK_WIDTH : 16;
  localparam logic [CntW-1:0]        LenCap   = CntW'(1) << LEN_WIDTH;
  localparam logic [BLOCK_WIDTH-1:0] BlockMax = '1;

  frlv_pkg::phase_e       phase_q, phase_d;
  logic [3:0]             pos_q, pos_d;
  logic [3:0]             kc_q, kc_d;
  logic [CntW-1:0]        tok_q, tok_d;
  logic [BLOCK_WIDTH-1:0] acc_q, acc_d;
  logic                   fdz_q, fdz_d;
  logic [1:0]             tc_q, tc_d;
  logic                   node_q, node_d;
  logic                   pfs_q, pfs_d;
  logic [7:0]             prev_q, prev_d;
  logic [CntW-1:0]        user_q, user_d;
  logic [CntW-1:0]        plen_q, plen_d;

  logic                   bad;
  logic [3:0]             sel, nm;
  logic [ProdW-1:0]       prod;
  logic [CntW-1:0]        tok_inc;
  logic                   complete;
  logic [CntW-1:0]        plen_chk;
  frlv_pkg::kind_e        kd, kd_path;
  frlv_pkg::err_e         err;
  frlv_pkg::tag_e         tag;
  logic [WideW-1:0]       acc_w;
  logic                   rw;

  assign tok_inc = (tok_q < LenCap) ? tok_q + CntW'(1) : tok_q;
  assign prod    = (ProdW'(acc_q) << 3) + (ProdW'(acc_q) << 1)
                 + ProdW'(char_i - frlv_pkg::CH_ZERO);
  assign kd_path = frlv_pkg::kind_of(kc_q);

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    kc_d    = kc_q;
    tok_d   = tok_q;
    acc_d   = acc_q;
    fdz_d   = fdz_q;
    tc_d    = tc_q;
    node_d  = node_q;
    pfs_d   = pfs_q;
    prev_d  = prev_q;
    user_d  = user_q;
    plen_d  = plen_q;
    bad     = 1'b0;
    tag     = frlv_pkg::TAG_ERROR;
    sel     = '0;
    nm      = '0;
    case (phase_q)
      frlv_pkg::PH_KEY: begin
        if (char_i == frlv_pkg::CH_SPACE) begin
          for (int k = 0; k < 4; k++) begin
            if (kc_q[k] && frlv_pkg::kw_len(2'(k)) == pos_q) begin
              sel    = '0;
              sel[k] = 1'b1;
            end
          end
          if (sel != '0) begin
            kc_d    = sel;
            phase_d = frlv_pkg::PH_USER;
            tok_d   = '0;
            tag     = frlv_pkg::TAG_SPACE;
          end else begin
            bad = 1'b1;
          end
        end else begin
          for (int k = 0; k < 4; k++) begin
            nm[k] = kc_q[k] && (pos_q < frlv_pkg::kw_len(2'(k)))
                    && (frlv_pkg::kw_char(2'(k), pos_q) == char_i);
          end
          kc_d = nm;
          if (pos_q < frlv_pkg::KeyPosMax) pos_d = pos_q + 4'd1;
          tag = frlv_pkg::TAG_KEYWORD;
          if (nm == '0) bad = 1'b1;
        end
      end
      frlv_pkg::PH_USER: begin
        if (char_i == frlv_pkg::CH_SPACE) begin
          if (tok_q == '0) begin
            bad = 1'b1;
          end else begin
            user_d  = tok_q;
            tok_d   = '0;
            phase_d = frlv_pkg::PH_PATH;
            tag     = frlv_pkg::TAG_SPACE;
          end
        end else if (frlv_pkg::is_ws(char_i)) begin
          bad = 1'b1;
        end else begin
          tok_d = tok_inc;
          tag   = frlv_pkg::TAG_USER;
        end
      end
      frlv_pkg::PH_PATH: begin
        if (char_i == frlv_pkg::CH_SPACE) begin
          if (tok_q == '0 || kd_path == frlv_pkg::KIND_DELETE) begin
            bad = 1'b1;
          end else begin
            plen_d  = tok_q;
            tok_d   = '0;
            phase_d = (kd_path == frlv_pkg::KIND_CREATE) ? frlv_pkg::PH_TYPE
                                                         : frlv_pkg::PH_DIGIT;
            tag     = frlv_pkg::TAG_SPACE;
          end
        end else if (frlv_pkg::is_ws(char_i)) begin
          bad = 1'b1;
        end else begin
          if (tok_q == '0) pfs_d = (char_i == frlv_pkg::CH_SLASH);
          prev_d = char_i;
          tok_d  = tok_inc;
          tag    = frlv_pkg::TAG_PATH;
        end
      end
      frlv_pkg::PH_DIGIT: begin
        if (char_i >= frlv_pkg::CH_ZERO && char_i <= frlv_pkg::CH_NINE) begin
          if (tok_q == '0) fdz_d = (char_i == frlv_pkg::CH_ZERO);
          acc_d = (prod[ProdW-1:BLOCK_WIDTH] != '0) ? BlockMax : prod[BLOCK_WIDTH-1:0];
          tok_d = tok_inc;
          tag   = frlv_pkg::TAG_DIGIT;
        end else begin
          bad = 1'b1;
        end
      end
      frlv_pkg::PH_TYPE: begin
        if (char_i == frlv_pkg::CH_LOW_F || char_i == frlv_pkg::CH_LOW_D) begin
          node_d = (char_i == frlv_pkg::CH_LOW_D);
          if (tc_q < 2'd2) tc_d = tc_q + 2'd1;
          tag = frlv_pkg::TAG_TYPE;
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase
    if (bad) phase_d = frlv_pkg::PH_BAD;
    if (phase_d == frlv_pkg::PH_BAD) tag = frlv_pkg::TAG_ERROR;

    // verdict, from the state as this beat leaves it
    kd       = frlv_pkg::kind_of(kc_d);
    rw       = (kd == frlv_pkg::KIND_READ) || (kd == frlv_pkg::KIND_WRITE);
    acc_w    = WideW'(acc_d);
    complete = 1'b0;
    plen_chk = plen_d;
    if (phase_d == frlv_pkg::PH_PATH && kd == frlv_pkg::KIND_DELETE && tok_d != '0) begin
      complete = 1'b1;
      plen_chk = tok_d;
    end else if (phase_d == frlv_pkg::PH_DIGIT && tok_d != '0) begin
      complete = 1'b1;
    end else if (phase_d == frlv_pkg::PH_TYPE && tc_d != 2'd0) begin
      complete = 1'b1;
    end

    if (!complete)
      err = frlv_pkg::ERR_MALFORMED;
    else if (kd == frlv_pkg::KIND_CREATE && tc_d > 2'd1)
      err = frlv_pkg::ERR_TYPE_TOKEN;
    else if (rw && fdz_d && tok_d > CntW'(1))
      err = frlv_pkg::ERR_LEAD_ZERO;
    else if (rw && acc_w >= WideW'(cfg_i.block_limit))
      err = frlv_pkg::ERR_BLOCK;
    else if (user_d == '0 || CmpW'(user_d) > CmpW'(cfg_i.user_len_limit))
      err = frlv_pkg::ERR_USER_LEN;
    else if (CmpW'(plen_chk) > CmpW'(cfg_i.path_len_limit))
      err = frlv_pkg::ERR_PATH_LEN;
    else if (!pfs_d || prev_d == frlv_pkg::CH_SLASH)
      err = frlv_pkg::ERR_PATH_FORM;
    else
      err = frlv_pkg::ERR_NONE;

    res_o              = '0;
    res_o.char_out     = char_i;
    res_o.field_tag    = tag;
    res_o.request_kind = frlv_pkg::KIND_READ;
    res_o.error_code   = frlv_pkg::ERR_NONE;
    if (last_i) begin
      res_o.done_res   = 1'b1;
      res_o.accepted   = (err == frlv_pkg::ERR_NONE);
      res_o.error_code = err;
      if (err == frlv_pkg::ERR_MALFORMED) begin
        res_o.field_tag = frlv_pkg::TAG_ERROR;
      end else begin
        res_o.request_kind = kd;
        if (rw) res_o.block_index = (acc_w > WideW'(16'hFFFF)) ? 16'hFFFF : acc_w[15:0];
        if (kd == frlv_pkg::KIND_CREATE) res_o.node_kind = node_d;
      end
      // message ends: back to the idle parse state
      phase_d = frlv_pkg::PH_KEY;
      pos_d   = '0;
      kc_d    = 4'hF;
      tok_d   = '0;
      acc_d   = '0;
      fdz_d   = 1'b0;
      tc_d    = '0;
      node_d  = 1'b0;
      pfs_d   = 1'b0;
      prev_d  = '0;
      user_d  = '0;
      plen_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= frlv_pkg::PH_KEY;
      pos_q   <= '0;
      kc_q    <= 4'hF;
      tok_q   <= '0;
      acc_q   <= '0;
      fdz_q   <= 1'b0;
      tc_q    <= '0;
      node_q  <= 1'b0;
      pfs_q   <= 1'b0;
      prev_q  <= '0;
      user_q  <= '0;
      plen_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      kc_q    <= kc_d;
      tok_q   <= tok_d;
      acc_q   <= acc_d;
      fdz_q   <= fdz_d;
      tc_q    <= tc_d;
      node_q  <= node_d;
      pfs_q   <= pfs_d;
      prev_q  <= prev_d;
      user_q  <= user_d;
      plen_q  <= plen_d;
    end
  end

endmodule
